/* rtl/yuvargb_pkg.sv */
// shared types and constants for the yuv to argb rotating pixel writer
`default_nettype none

package yuvargb_pkg;

    // frame geometry
    localparam int MAX_DIM = 4096;
    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = 13;
    localparam int ROT_W   = 2;
    localparam int ADDR_W  = 24;

    // pixel widths
    localparam int PIX_W   = 8;
    localparam int ARGB_W  = 32;

    // apb register file
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes
    typedef enum logic [1:0] {
        REG_ROTATION     = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2,
        REG_OUT_STRIDE   = 2'd3
    } t_reg_idx;

    // rotation codes
    typedef enum logic [ROT_W-1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    // register reset values
    localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);
    localparam logic [DIM_W-1:0] RST_STRIDE = DIM_W'(640);

    // bt.601 conversion constants, coefficients scaled by 1024
    localparam int CSUM_W = 21;
    localparam logic [PIX_W-1:0] LUMA_OFS   = PIX_W'(16);
    localparam int               CHROMA_OFS = 128;
    localparam int               K_Y        = 1192;
    localparam int               K_RV       = 1634;
    localparam int               K_GV       = 833;
    localparam int               K_GU       = 400;
    localparam int               K_BU       = 2066;
    localparam logic [7:0]       ALPHA      = 8'hff;

    // pixel held between the input and result registers
    typedef struct packed {
        logic [PIX_W-1:0]  luma;
        logic [PIX_W-1:0]  chroma_blue;
        logic [PIX_W-1:0]  chroma_red;
        logic [ADDR_W-1:0] mul_term;
        logic [ADDR_W-1:0] add_term;
        logic              frame_last;
    } t_stage;

endpackage

`default_nettype wire

/* rtl/yuvargb_if.sv */
// valid/ready stream interfaces for yuv pixels in and argb pixels out
`default_nettype none

interface yuvargb_in_if;
    logic                          valid;
    logic                          ready;
    logic [yuvargb_pkg::PIX_W-1:0] luma;
    logic [yuvargb_pkg::PIX_W-1:0] chroma_blue;
    logic [yuvargb_pkg::PIX_W-1:0] chroma_red;

    modport source (output valid, luma, chroma_blue, chroma_red, input ready);
    modport sink   (input valid, luma, chroma_blue, chroma_red, output ready);
endinterface

interface yuvargb_out_if;
    logic                           valid;
    logic                           ready;
    logic [yuvargb_pkg::ARGB_W-1:0] argb_word;
    logic [yuvargb_pkg::ADDR_W-1:0] dest_address;
    logic                           frame_last;

    modport source (output valid, argb_word, dest_address, frame_last, input ready);
    modport sink   (input valid, argb_word, dest_address, frame_last, output ready);
endinterface

`default_nettype wire

/* rtl/yuv_to_argb_rotating_pixel_writer.sv */
// Converts a raster stream of Y/U/V pixels to opaque BT.601 ARGB words and
// computes each pixel's destination word address for a rotation of 0, 90, 180
// or 270 degrees over the programmed width, height and stride; frame_last
// marks the final pixel of each frame. One pixel is taken per clock while
// back-pressure does not hold the pipeline. The first register stage
// holds the pixel with its address operands taken from the column and
// row counters, the second holds the converted color and the address from
// the single stride multiply. Back-pressure stalls both stages in place.
// Registers (APB, byte address 4*i): 0 rotation, 1 frame width, 2 frame
// height, 3 output stride. Write them only while no pixel is in flight.
`default_nettype none

module yuv_to_argb_rotating_pixel_writer (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // apb configuration port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [yuvargb_pkg::PADDR_W-1:0]     paddr,
    input  wire  [yuvargb_pkg::PDATA_W-1:0]     pwdata,
    output logic [yuvargb_pkg::PDATA_W-1:0]     prdata,
    output logic                                pready,
    // pixel streams
    yuvargb_in_if.sink                          i_pix,
    yuvargb_out_if.source                       o_pix
);

    // configuration registers
    logic [yuvargb_pkg::ROT_W-1:0]  r_rotation;
    logic [yuvargb_pkg::DIM_W-1:0]  r_frame_width;
    logic [yuvargb_pkg::DIM_W-1:0]  r_frame_height;
    logic [yuvargb_pkg::DIM_W-1:0]  r_out_stride;

    // position counters
    logic [yuvargb_pkg::CNT_W-1:0]  r_col;
    logic [yuvargb_pkg::CNT_W-1:0]  r_row;
    logic [yuvargb_pkg::CNT_W-1:0]  n_col;
    logic [yuvargb_pkg::CNT_W-1:0]  n_row;

    // pipeline registers
    logic                           r_stg_valid;
    yuvargb_pkg::t_stage            r_stg;
    yuvargb_pkg::t_stage            n_stg;
    logic                           r_out_valid;
    logic [yuvargb_pkg::ARGB_W-1:0] r_out_argb;
    logic [yuvargb_pkg::ADDR_W-1:0] r_out_addr;
    logic                           r_out_last;
    logic [yuvargb_pkg::ARGB_W-1:0] n_out_argb;
    logic [yuvargb_pkg::ADDR_W-1:0] n_out_addr;

    // handshake
    logic                           out_free;
    logic                           stg_free;
    logic                           in_take;
    logic                           cfg_wr;
    yuvargb_pkg::t_reg_idx          cfg_idx;

    // geometry helpers
    logic [yuvargb_pkg::DIM_W-1:0]  width_cl;
    logic [yuvargb_pkg::DIM_W-1:0]  height_cl;
    logic [yuvargb_pkg::ADDR_W-1:0] col_ext;
    logic [yuvargb_pkg::ADDR_W-1:0] row_ext;
    logic [yuvargb_pkg::ADDR_W-1:0] col_flip;
    logic [yuvargb_pkg::ADDR_W-1:0] row_flip;
    logic                           row_end;
    logic                           frame_end;

    // color helpers
    logic [yuvargb_pkg::PIX_W-1:0]          luma_ofs;
    logic signed [yuvargb_pkg::CSUM_W-1:0]  y_s;
    logic signed [yuvargb_pkg::CSUM_W-1:0]  u_s;
    logic signed [yuvargb_pkg::CSUM_W-1:0]  v_s;
    logic signed [yuvargb_pkg::CSUM_W-1:0]  r_sum;
    logic signed [yuvargb_pkg::CSUM_W-1:0]  g_sum;
    logic signed [yuvargb_pkg::CSUM_W-1:0]  b_sum;

    // clamp a channel sum to 0..262143 and keep bits 17:10
    function automatic logic [7:0] chan_clip(input logic signed [yuvargb_pkg::CSUM_W-1:0] s);
        logic [7:0] res;
        if (s[yuvargb_pkg::CSUM_W-1]) begin
            res = 8'd0;
        end else if (s[yuvargb_pkg::CSUM_W-2:18] != '0) begin
            res = 8'hff;
        end else begin
            res = s[17:10];
        end
        return res;
    endfunction

    // apb decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = yuvargb_pkg::t_reg_idx'(paddr[3:2]);

    // register read mux
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            yuvargb_pkg::REG_ROTATION:     prdata = yuvargb_pkg::PDATA_W'(r_rotation);
            yuvargb_pkg::REG_FRAME_WIDTH:  prdata = yuvargb_pkg::PDATA_W'(r_frame_width);
            yuvargb_pkg::REG_FRAME_HEIGHT: prdata = yuvargb_pkg::PDATA_W'(r_frame_height);
            yuvargb_pkg::REG_OUT_STRIDE:   prdata = yuvargb_pkg::PDATA_W'(r_out_stride);
            default:                       prdata = '0;
        endcase
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation     <= yuvargb_pkg::ROT_0;
            r_frame_width  <= yuvargb_pkg::RST_WIDTH;
            r_frame_height <= yuvargb_pkg::RST_HEIGHT;
            r_out_stride   <= yuvargb_pkg::RST_STRIDE;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                yuvargb_pkg::REG_ROTATION:
                    r_rotation <= pwdata[yuvargb_pkg::ROT_W-1:0];
                yuvargb_pkg::REG_FRAME_WIDTH:
                    r_frame_width <= pwdata[yuvargb_pkg::DIM_W-1:0];
                yuvargb_pkg::REG_FRAME_HEIGHT:
                    r_frame_height <= pwdata[yuvargb_pkg::DIM_W-1:0];
                yuvargb_pkg::REG_OUT_STRIDE:
                    r_out_stride <= pwdata[yuvargb_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign out_free    = !r_out_valid || o_pix.ready;
    assign stg_free    = !r_stg_valid || out_free;
    assign i_pix.ready = stg_free;
    assign in_take     = i_pix.valid && stg_free;

    // clamp frame size to 1..MAX_DIM
    always_comb begin
        width_cl = r_frame_width;
        if (r_frame_width == '0) begin
            width_cl = yuvargb_pkg::DIM_W'(1);
        end else if (r_frame_width > yuvargb_pkg::DIM_W'(yuvargb_pkg::MAX_DIM)) begin
            width_cl = yuvargb_pkg::DIM_W'(yuvargb_pkg::MAX_DIM);
        end
        height_cl = r_frame_height;
        if (r_frame_height == '0) begin
            height_cl = yuvargb_pkg::DIM_W'(1);
        end else if (r_frame_height > yuvargb_pkg::DIM_W'(yuvargb_pkg::MAX_DIM)) begin
            height_cl = yuvargb_pkg::DIM_W'(yuvargb_pkg::MAX_DIM);
        end
    end

    // mirrored coordinates, wrapping in address width
    assign col_ext  = yuvargb_pkg::ADDR_W'(r_col);
    assign row_ext  = yuvargb_pkg::ADDR_W'(r_row);
    assign col_flip = yuvargb_pkg::ADDR_W'(width_cl) - yuvargb_pkg::ADDR_W'(1) - col_ext;
    assign row_flip = yuvargb_pkg::ADDR_W'(height_cl) - yuvargb_pkg::ADDR_W'(1) - row_ext;

    // end of row and frame
    assign row_end   = yuvargb_pkg::DIM_W'(r_col) >= (width_cl - yuvargb_pkg::DIM_W'(1));
    assign frame_end = row_end &&
                       (yuvargb_pkg::DIM_W'(r_row) >= (height_cl - yuvargb_pkg::DIM_W'(1)));

    // address operands and captured pixel
    always_comb begin
        n_stg.luma        = i_pix.luma;
        n_stg.chroma_blue = i_pix.chroma_blue;
        n_stg.chroma_red  = i_pix.chroma_red;
        n_stg.frame_last  = frame_end;
        n_stg.mul_term    = row_ext;
        n_stg.add_term    = col_ext;
        case (yuvargb_pkg::t_rot'(r_rotation))
            yuvargb_pkg::ROT_0: begin
                n_stg.mul_term = row_ext;
                n_stg.add_term = col_ext;
            end
            yuvargb_pkg::ROT_90: begin
                n_stg.mul_term = col_ext;
                n_stg.add_term = row_flip;
            end
            yuvargb_pkg::ROT_180: begin
                n_stg.mul_term = row_flip;
                n_stg.add_term = col_flip;
            end
            default: begin
                n_stg.mul_term = col_flip;
                n_stg.add_term = row_ext;
            end
        endcase
    end

    // next column and row
    always_comb begin
        n_col = r_col + yuvargb_pkg::CNT_W'(1);
        n_row = r_row;
        if (row_end) begin
            n_col = '0;
            n_row = frame_end ? '0 : r_row + yuvargb_pkg::CNT_W'(1);
        end
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_take) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (stg_free) begin
            r_stg_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_stg <= n_stg;
        end
    end

    // bt.601 color conversion
    always_comb begin
        luma_ofs = (r_stg.luma >= yuvargb_pkg::LUMA_OFS) ?
                   (r_stg.luma - yuvargb_pkg::LUMA_OFS) : '0;
        y_s   = $signed(yuvargb_pkg::CSUM_W'(luma_ofs));
        u_s   = $signed(yuvargb_pkg::CSUM_W'(r_stg.chroma_blue))
              - yuvargb_pkg::CSUM_W'(yuvargb_pkg::CHROMA_OFS);
        v_s   = $signed(yuvargb_pkg::CSUM_W'(r_stg.chroma_red))
              - yuvargb_pkg::CSUM_W'(yuvargb_pkg::CHROMA_OFS);
        r_sum = y_s * yuvargb_pkg::CSUM_W'(yuvargb_pkg::K_Y)
              + v_s * yuvargb_pkg::CSUM_W'(yuvargb_pkg::K_RV);
        g_sum = y_s * yuvargb_pkg::CSUM_W'(yuvargb_pkg::K_Y)
              - v_s * yuvargb_pkg::CSUM_W'(yuvargb_pkg::K_GV)
              - u_s * yuvargb_pkg::CSUM_W'(yuvargb_pkg::K_GU);
        b_sum = y_s * yuvargb_pkg::CSUM_W'(yuvargb_pkg::K_Y)
              + u_s * yuvargb_pkg::CSUM_W'(yuvargb_pkg::K_BU);
        n_out_argb = {yuvargb_pkg::ALPHA, chan_clip(r_sum), chan_clip(g_sum), chan_clip(b_sum)};
    end

    // stride multiply and offset, wrapping in address width
    assign n_out_addr = yuvargb_pkg::ADDR_W'(r_stg.mul_term * yuvargb_pkg::ADDR_W'(r_out_stride))
                      + r_stg.add_term;

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_stg_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_stg_valid) begin
            r_out_argb <= n_out_argb;
            r_out_addr <= n_out_addr;
            r_out_last <= r_stg.frame_last;
        end
    end

    // result port
    assign o_pix.valid        = r_out_valid;
    assign o_pix.argb_word    = r_out_argb;
    assign o_pix.dest_address = r_out_addr;
    assign o_pix.frame_last   = r_out_last;

endmodule

`default_nettype wire

/* sim/tb_yuv_to_argb_rotating_pixel_writer.sv */
// testbench for the yuv to argb rotating pixel writer: predicted colors, addresses and frame ends
`timescale 1ns / 1ps

module tb_yuv_to_argb_rotating_pixel_writer;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int RANDOM_PIXELS  = 820;
    localparam int MAX_REPORTS    = 10;

    // bt.601 coefficients scaled by 1024, kept apart from the design's copy
    localparam int COEF_Y   = 1192;
    localparam int COEF_RV  = 1634;
    localparam int COEF_GV  = 833;
    localparam int COEF_GU  = 400;
    localparam int COEF_BU  = 2066;
    localparam int CHAN_TOP = 262143;

    typedef struct {
        logic [31:0] argb;
        logic [23:0] addr;
        logic        last;
    } t_pixel_result;

    logic i_clk;
    logic i_rst_n;

    // apb port
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [yuvargb_pkg::PADDR_W-1:0]  paddr;
    logic [yuvargb_pkg::PDATA_W-1:0]  pwdata;
    logic [yuvargb_pkg::PDATA_W-1:0]  prdata;
    logic                             pready;

    yuvargb_in_if  pix_in ();
    yuvargb_out_if pix_out ();

    yuv_to_argb_rotating_pixel_writer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    // predictor copy of the registers and the raster position
    yuvargb_pkg::t_rot cfg_rot;
    logic [12:0] cfg_width;
    logic [12:0] cfg_height;
    logic [12:0] cfg_stride;
    logic [31:0] col_pos;
    logic [31:0] row_pos;

    t_pixel_result expected_pixels[$];
    int error_count;
    int idle_cycles;
    int burst_left;
    bit gaps_enabled;
    bit holdoff_req;
    int pixels_sent;

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] clamp_channel(int v);
        if (v < 0) v = 0;
        if (v > CHAN_TOP) v = CHAN_TOP;
        return 8'(v >> 10);
    endfunction

    function automatic logic [31:0] convert_bt601(logic [7:0] y, logic [7:0] u, logic [7:0] v);
        int yy;
        int uu;
        int vv;
        yy = y;
        uu = u;
        vv = v;
        yy = yy - 16;
        uu = uu - 128;
        vv = vv - 128;
        if (yy < 0) yy = 0;
        return {8'hff,
                clamp_channel(COEF_Y * yy + COEF_RV * vv),
                clamp_channel(COEF_Y * yy - COEF_GV * vv - COEF_GU * uu),
                clamp_channel(COEF_Y * yy + COEF_BU * uu)};
    endfunction

    function automatic logic [31:0] clamp_dim(logic [12:0] d);
        if (d == 13'd0) return 32'd1;
        if (d > 13'(yuvargb_pkg::MAX_DIM)) return 32'(yuvargb_pkg::MAX_DIM);
        return 32'(d);
    endfunction

    // converts one pixel and advances the raster position
    function automatic t_pixel_result predict_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v);
        t_pixel_result res;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] s;
        logic [31:0] a;
        logic row_end;
        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        s = 32'(cfg_stride);
        case (cfg_rot)
            yuvargb_pkg::ROT_0:   a = row_pos * s + col_pos;
            yuvargb_pkg::ROT_90:  a = col_pos * s + (h - 32'd1 - row_pos);
            yuvargb_pkg::ROT_180: a = (h - 32'd1 - row_pos) * s + (w - 32'd1 - col_pos);
            default:              a = (w - 32'd1 - col_pos) * s + row_pos;
        endcase
        row_end  = (col_pos >= w - 32'd1);
        res.argb = convert_bt601(y, u, v);
        res.addr = a[23:0];
        res.last = row_end && (row_pos >= h - 32'd1);
        if (row_end) begin
            col_pos = 32'd0;
            row_pos = res.last ? 32'd0 : row_pos + 32'd1;
        end else begin
            col_pos = col_pos + 32'd1;
        end
        return res;
    endfunction

    function automatic logic [7:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd16;
            3: return 8'd128;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    // predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && pix_in.valid && pix_in.ready)
            expected_pixels.push_back(predict_pixel(pix_in.luma, pix_in.chroma_blue,
                                                    pix_in.chroma_red));
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (expected_pixels.size() == 0) begin
                note_mismatch("unexpected result", 32'd0, pix_out.argb_word);
            end else begin
                want = expected_pixels.pop_front();
                if (pix_out.argb_word !== want.argb)
                    note_mismatch("argb_word", want.argb, pix_out.argb_word);
                if (pix_out.dest_address !== want.addr)
                    note_mismatch("dest_address", 32'(want.addr), 32'(pix_out.dest_address));
                if (pix_out.frame_last !== want.last)
                    note_mismatch("frame_last", 32'(want.last), 32'(pix_out.frame_last));
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stall patterns plus a long hold-off on request
    initial begin
        int mode_left;
        int stall_mode;
        int tick;
        mode_left  = 0;
        stall_mode = 0;
        tick       = 0;
        pix_out.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            tick++;
            if (holdoff_req) begin
                pix_out.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                holdoff_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(8, 64);
                end
                mode_left--;
                case (stall_mode)
                    0: pix_out.ready <= 1'b1;
                    1: pix_out.ready <= 1'($urandom_range(0, 1));
                    2: pix_out.ready <= ($urandom_range(0, 3) == 0);
                    default: pix_out.ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // one pixel request, with burst gaps when enabled
    task automatic send_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v);
        int gap;
        if (gaps_enabled && burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                pix_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        pix_in.valid       <= 1'b1;
        pix_in.luma        <= y;
        pix_in.chroma_blue <= u;
        pix_in.chroma_red  <= v;
        do @(posedge i_clk); while (!pix_in.ready);
        pixels_sent++;
    endtask

    task automatic send_random_pixels(int count);
        repeat (count) send_pixel(random_sample(), random_sample(), random_sample());
    endtask

    // stop requests and wait until every result is back
    task automatic wait_pixels_drained();
        pix_in.valid <= 1'b0;
        do @(posedge i_clk); while (expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(yuvargb_pkg::t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= yuvargb_pkg::PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            yuvargb_pkg::REG_ROTATION:     cfg_rot    = yuvargb_pkg::t_rot'(value[1:0]);
            yuvargb_pkg::REG_FRAME_WIDTH:  cfg_width  = value[12:0];
            yuvargb_pkg::REG_FRAME_HEIGHT: cfg_height = value[12:0];
            default:                       cfg_stride = value[12:0];
        endcase
    endtask

    task automatic check_reg(yuvargb_pkg::t_reg_idx idx, logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= yuvargb_pkg::PADDR_W'(idx) << 2;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) note_mismatch(idx.name(), want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(yuvargb_pkg::t_rot rot, logic [31:0] w, logic [31:0] h,
                             logic [31:0] s);
        write_reg(yuvargb_pkg::REG_ROTATION, 32'(rot));
        write_reg(yuvargb_pkg::REG_FRAME_WIDTH, w);
        write_reg(yuvargb_pkg::REG_FRAME_HEIGHT, h);
        write_reg(yuvargb_pkg::REG_OUT_STRIDE, s);
    endtask

    // color extremes under the reset geometry
    task automatic test_color_extremes();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd16,  8'd128, 8'd128);
        send_pixel(8'd15,  8'd0,   8'd255);
        send_pixel(8'd235, 8'd255, 8'd0);
        send_pixel(8'd128, 8'd0,   8'd0);
        wait_pixels_drained();
    endtask

    // reset values, masking on write and read-back
    task automatic test_register_readback();
        check_reg(yuvargb_pkg::REG_ROTATION, 32'(yuvargb_pkg::ROT_0));
        check_reg(yuvargb_pkg::REG_FRAME_WIDTH, 32'd640);
        check_reg(yuvargb_pkg::REG_FRAME_HEIGHT, 32'd480);
        check_reg(yuvargb_pkg::REG_OUT_STRIDE, 32'd640);
        write_reg(yuvargb_pkg::REG_ROTATION, 32'hffff_fffe);
        write_reg(yuvargb_pkg::REG_FRAME_WIDTH, 32'h0001_e123);
        write_reg(yuvargb_pkg::REG_FRAME_HEIGHT, 32'hffff_ffff);
        write_reg(yuvargb_pkg::REG_OUT_STRIDE, 32'h8000_0005);
        check_reg(yuvargb_pkg::REG_ROTATION, 32'(yuvargb_pkg::ROT_180));
        check_reg(yuvargb_pkg::REG_FRAME_WIDTH, 32'h0123);
        check_reg(yuvargb_pkg::REG_FRAME_HEIGHT, 32'h1fff);
        check_reg(yuvargb_pkg::REG_OUT_STRIDE, 32'h0005);
    endtask

    // every rotation over a 2x2 frame, counters left mid-frame by the color extremes test
    task automatic test_rotation_small_frames();
        yuvargb_pkg::t_rot rot;
        rot = yuvargb_pkg::ROT_0;
        do begin
            set_frame(rot, 32'd2, 32'd2, 32'd3);
            send_random_pixels(4);
            wait_pixels_drained();
            rot = yuvargb_pkg::t_rot'(rot + 1);
        end while (rot != yuvargb_pkg::ROT_0);
    endtask

    // zero and oversized dimensions, zero stride, address wrap
    task automatic test_dimension_limits();
        set_frame(yuvargb_pkg::ROT_90, 32'd0, 32'd0, 32'd0);
        send_random_pixels(3);
        wait_pixels_drained();
        set_frame(yuvargb_pkg::ROT_270, 32'd8191, 32'd8191, 32'd8191);
        send_random_pixels(3);
        wait_pixels_drained();
        set_frame(yuvargb_pkg::ROT_180, 32'd4096, 32'd4096, 32'd4096);
        send_random_pixels(2);
        wait_pixels_drained();
    endtask

    function automatic logic [31:0] random_dim();
        case ($urandom_range(0, 11))
            0: return 32'd0;
            1: return 32'd4096;
            2: return 32'($urandom_range(4097, 8191));
            3: return 32'($urandom_range(9, 64));
            default: return 32'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [31:0] random_stride();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd8191;
            2: return 32'($urandom_range(1, 8191));
            default: return 32'($urandom_range(1, 12));
        endcase
    endfunction

    // random geometry phases, mostly small frames so many frames complete
    task automatic test_random_frames();
        int target;
        target = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < target) begin
            set_frame(yuvargb_pkg::t_rot'($urandom_range(0, 3)), random_dim(), random_dim(),
                      random_stride());
            send_random_pixels($urandom_range(30, 110));
            wait_pixels_drained();
        end
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_output_holdoff();
        set_frame(yuvargb_pkg::ROT_90, 32'd5, 32'd4, 32'd7);
        gaps_enabled = 1'b0;
        holdoff_req  = 1'b1;
        send_random_pixels(64);
        gaps_enabled = 1'b1;
        wait_pixels_drained();
    endtask

    initial begin
        cfg_rot      = yuvargb_pkg::ROT_0;
        cfg_width    = 13'd640;
        cfg_height   = 13'd480;
        cfg_stride   = 13'd640;
        col_pos      = 32'd0;
        row_pos      = 32'd0;
        error_count  = 0;
        burst_left   = 0;
        gaps_enabled = 1'b1;
        holdoff_req  = 1'b0;
        pixels_sent  = 0;
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        pix_in.valid       <= 1'b0;
        pix_in.luma        <= '0;
        pix_in.chroma_blue <= '0;
        pix_in.chroma_red  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_color_extremes();
        test_register_readback();
        test_rotation_small_frames();
        test_dimension_limits();
        test_output_holdoff();
        test_random_frames();
        wait_pixels_drained();

        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/yuvargb_pkg.sv
rtl/yuvargb_if.sv
rtl/yuv_to_argb_rotating_pixel_writer.sv
sim/tb_yuv_to_argb_rotating_pixel_writer.sv
